### rtl/core/sip_pkg.sv
// ============================================================================
// sip_pkg: shared constants for the segment intersection point block
// Default geometry widths and the fixed format of the hit coordinates.
// ============================================================================
`default_nettype none

package sip_pkg;

    // Default coordinate width and fraction width of the result.
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Hit coordinates are always 24-bit signed fixed point.
    localparam int HIT_BITS = 24;
    localparam int HIT_MAX  = 8388607;
    localparam int HIT_MIN  = -8388608;

    // Output beat: hit_x in the low half, hit_y in the high half.
    localparam int M_DATA_BITS = 2 * HIT_BITS;

endpackage

`default_nettype wire

### rtl/core/segment_intersection_point.sv
// ============================================================================
// segment_intersection_point: proper crossing point of two segments
// Tests two integer segments AB and CD for a strict crossing and returns the
// crossing point in signed fixed point, or (0,0) with the flag clear.
// ============================================================================
// One segment pair enters per clock and one result leaves per clock while
// the output is not held off. The path runs through the cross products and
// the crossing test, the dividend multiply, the pipelined restoring divider,
// which is the longest part, and rounding and placement. Every stage holds
// under back-pressure and fills bubbles, so a waiting result does not block
// new pairs until the pipeline is full. There is no configuration and no
// state between pairs.
`default_nettype none

module segment_intersection_point #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up
    input  logic [8*COORD_BITS-1:0]          s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit_x, hit_y from the lowest bit up
    output logic [sip_pkg::M_DATA_BITS-1:0]  m_tdata,
    // crossed
    output logic [0:0]                       m_tuser
);

    import sip_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int QW = COORD_BITS + FRAC_BITS;
    localparam int DW = 2 * COORD_BITS + 2;
    localparam int NW = 3 * COORD_BITS + FRAC_BITS + 1;
    localparam int SW = 2 * COORD_BITS + 3;

    logic               w_cr_valid;
    logic               w_cr_ready;
    logic               w_cr_crossed;
    logic [2*C:0]       w_cr_wa;
    logic [DW-1:0]      w_cr_sum;
    logic [C-1:0]       w_cr_mag_x;
    logic [C-1:0]       w_cr_mag_y;
    logic               w_cr_neg_x;
    logic               w_cr_neg_y;
    logic [C-1:0]       w_cr_base_x;
    logic [C-1:0]       w_cr_base_y;
    logic [SW-1:0]      w_cr_side;
    logic               w_sc_valid;
    logic               w_sc_ready;
    logic [NW-1:0]      w_sc_num_x;
    logic [NW-1:0]      w_sc_num_y;
    logic [DW-1:0]      w_sc_den;
    logic [SW-1:0]      w_sc_side;
    logic               w_dv_valid;
    logic               w_dv_ready;
    logic [QW-1:0]      w_dv_quo_x;
    logic [QW-1:0]      w_dv_quo_y;
    logic [DW-1:0]      w_dv_rem_x;
    logic [DW-1:0]      w_dv_rem_y;
    logic [DW-1:0]      w_dv_den;
    logic [SW-1:0]      w_dv_side;
    logic [HIT_BITS-1:0] w_hit_x;
    logic [HIT_BITS-1:0] w_hit_y;

    // Orientation tests.
    sip_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_data    (s_tdata),
        .o_valid   (w_cr_valid),
        .i_ready   (w_cr_ready),
        .o_crossed (w_cr_crossed),
        .o_wa      (w_cr_wa),
        .o_sum     (w_cr_sum),
        .o_mag_x   (w_cr_mag_x),
        .o_mag_y   (w_cr_mag_y),
        .o_neg_x   (w_cr_neg_x),
        .o_neg_y   (w_cr_neg_y),
        .o_base_x  (w_cr_base_x),
        .o_base_y  (w_cr_base_y)
    );

    // Fields that ride along to placement.
    assign w_cr_side = {w_cr_crossed, w_cr_neg_y, w_cr_neg_x, w_cr_base_y, w_cr_base_x};

    // Dividend |B - A| * |dA| * 2^FRAC_BITS.
    sip_scale #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_BITS  (SW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cr_valid),
        .o_ready (w_cr_ready),
        .i_wa    (w_cr_wa),
        .i_sum   (w_cr_sum),
        .i_mag_x (w_cr_mag_x),
        .i_mag_y (w_cr_mag_y),
        .i_side  (w_cr_side),
        .o_valid (w_sc_valid),
        .i_ready (w_sc_ready),
        .o_num_x (w_sc_num_x),
        .o_num_y (w_sc_num_y),
        .o_den   (w_sc_den),
        .o_side  (w_sc_side)
    );

    // Division by |dA| + |dB| for both axes.
    sip_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_BITS  (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sc_valid),
        .o_ready (w_sc_ready),
        .i_num_x (w_sc_num_x),
        .i_num_y (w_sc_num_y),
        .i_den   (w_sc_den),
        .i_side  (w_sc_side),
        .o_valid (w_dv_valid),
        .i_ready (w_dv_ready),
        .o_quo_x (w_dv_quo_x),
        .o_quo_y (w_dv_quo_y),
        .o_rem_x (w_dv_rem_x),
        .o_rem_y (w_dv_rem_y),
        .o_den   (w_dv_den),
        .o_side  (w_dv_side)
    );

    // Rounding, placement and the output register.
    sip_place #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_place (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_dv_valid),
        .o_ready   (w_dv_ready),
        .i_quo_x   (w_dv_quo_x),
        .i_quo_y   (w_dv_quo_y),
        .i_rem_x   (w_dv_rem_x),
        .i_rem_y   (w_dv_rem_y),
        .i_den     (w_dv_den),
        .i_side    (w_dv_side),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_crossed (m_tuser[0]),
        .o_hit_x   (w_hit_x),
        .o_hit_y   (w_hit_y)
    );

    assign m_tdata = {w_hit_y, w_hit_x};

endmodule

`default_nettype wire

### rtl/core/sip_cross.sv
// ============================================================================
// sip_cross: orientation tests of two segments
// Four stages: coordinate differences, eight products, the four cross
// products, then the crossing test, |dA| and |dA| + |dB|.
// ============================================================================
`default_nettype none

module sip_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [8*COORD_BITS-1:0]   i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_crossed,
    output logic [2*COORD_BITS:0]     o_wa,
    output logic [2*COORD_BITS+1:0]   o_sum,
    output logic [COORD_BITS-1:0]     o_mag_x,
    output logic [COORD_BITS-1:0]     o_mag_y,
    output logic                      o_neg_x,
    output logic                      o_neg_y,
    output logic [COORD_BITS-1:0]     o_base_x,
    output logic [COORD_BITS-1:0]     o_base_y
);

    localparam int C      = COORD_BITS;
    localparam int PW     = 2 * C + 2;
    localparam int STAGES = 4;
    localparam int SDW    = 4 * C + 2;

    logic [STAGES-1:0]     r_v;
    logic [STAGES:0]       w_adv;
    logic signed [C:0]     w_pt   [8];
    logic signed [C:0]     w_dlt_x;
    logic signed [C:0]     w_dlt_y;
    logic signed [C:0]     w_ndl_x;
    logic signed [C:0]     w_ndl_y;
    logic [SDW-1:0]        w_side0;
    logic signed [C:0]     r_dif  [12];
    logic signed [PW-1:0]  r_prod [8];
    logic signed [PW-1:0]  r_crs  [4];
    logic signed [PW-1:0]  w_abs  [4];
    logic                  w_crossed;
    logic                  r_crossed;
    logic [2*C:0]          r_wa;
    logic [PW-1:0]         r_sum;
    logic [SDW-1:0]        r_side [STAGES];

    // A stage takes a new beat when it is empty or its successor moves on.
    assign w_adv[STAGES] = i_ready;
    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    endgenerate
    assign o_ready = w_adv[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < STAGES; s++) begin
                if (w_adv[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
                end
            end
        end
    end

    // Sign-extended coordinates: a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y.
    generate
        for (k = 0; k < 8; k++) begin : g_pt
            assign w_pt[k] = {i_data[k*C+C-1], i_data[k*C +: C]};
        end
    endgenerate

    // Direction of segment AB split into sign and magnitude.
    assign w_dlt_x = w_pt[2] - w_pt[0];
    assign w_dlt_y = w_pt[3] - w_pt[1];
    assign w_ndl_x = -w_dlt_x;
    assign w_ndl_y = -w_dlt_y;
    assign w_side0 = {
        (w_dlt_y[C] ? w_ndl_y[C-1:0] : w_dlt_y[C-1:0]),
        (w_dlt_x[C] ? w_ndl_x[C-1:0] : w_dlt_x[C-1:0]),
        w_dlt_y[C], w_dlt_x[C],
        i_data[C +: C], i_data[0 +: C]
    };

    // Stage 1 differences, stage 2 products, stage 3 cross products.
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_dif[0]  <= w_pt[4] - w_pt[6];
            r_dif[1]  <= w_pt[1] - w_pt[5];
            r_dif[2]  <= w_pt[5] - w_pt[7];
            r_dif[3]  <= w_pt[4] - w_pt[0];
            r_dif[4]  <= w_pt[3] - w_pt[5];
            r_dif[5]  <= w_pt[4] - w_pt[2];
            r_dif[6]  <= w_pt[0] - w_pt[2];
            r_dif[7]  <= w_pt[5] - w_pt[1];
            r_dif[8]  <= w_pt[1] - w_pt[3];
            r_dif[9]  <= w_pt[0] - w_pt[4];
            r_dif[10] <= w_pt[7] - w_pt[1];
            r_dif[11] <= w_pt[0] - w_pt[6];
            r_side[0] <= w_side0;
        end
        if (w_adv[1]) begin
            r_prod[0] <= PW'(r_dif[0]) * PW'(r_dif[1]);
            r_prod[1] <= PW'(r_dif[2]) * PW'(r_dif[3]);
            r_prod[2] <= PW'(r_dif[0]) * PW'(r_dif[4]);
            r_prod[3] <= PW'(r_dif[2]) * PW'(r_dif[5]);
            r_prod[4] <= PW'(r_dif[6]) * PW'(r_dif[7]);
            r_prod[5] <= PW'(r_dif[8]) * PW'(r_dif[9]);
            r_prod[6] <= PW'(r_dif[6]) * PW'(r_dif[10]);
            r_prod[7] <= PW'(r_dif[8]) * PW'(r_dif[11]);
            r_side[1] <= r_side[0];
        end
        if (w_adv[2]) begin
            r_crs[0]  <= r_prod[0] + r_prod[1];
            r_crs[1]  <= r_prod[2] + r_prod[3];
            r_crs[2]  <= r_prod[4] + r_prod[5];
            r_crs[3]  <= r_prod[6] + r_prod[7];
            r_side[2] <= r_side[1];
        end
        if (w_adv[3]) begin
            r_crossed <= w_crossed;
            r_wa      <= w_abs[0][2*C:0];
            r_sum     <= {1'b0, w_abs[0][2*C:0]} + {1'b0, w_abs[1][2*C:0]};
            r_side[3] <= r_side[2];
        end
    end

    // Proper crossing: both pairs strictly on opposite sides.
    generate
        for (k = 0; k < 4; k++) begin : g_abs
            assign w_abs[k] = r_crs[k][PW-1] ? -r_crs[k] : r_crs[k];
        end
    endgenerate
    assign w_crossed = (r_crs[0][PW-1] != r_crs[1][PW-1])
                    && (r_crs[0] != '0) && (r_crs[1] != '0)
                    && (r_crs[2][PW-1] != r_crs[3][PW-1])
                    && (r_crs[2] != '0) && (r_crs[3] != '0);

    assign o_crossed = r_crossed;
    assign o_wa      = r_wa;
    assign o_sum     = r_sum;
    assign o_base_x  = r_side[STAGES-1][0 +: C];
    assign o_base_y  = r_side[STAGES-1][C +: C];
    assign o_neg_x   = r_side[STAGES-1][2*C];
    assign o_neg_y   = r_side[STAGES-1][2*C+1];
    assign o_mag_x   = r_side[STAGES-1][2*C+2 +: C];
    assign o_mag_y   = r_side[STAGES-1][3*C+2 +: C];

endmodule

`default_nettype wire

### rtl/core/sip_scale.sv
// ============================================================================
// sip_scale: dividend forming for both axes
// Multiplies |B - A| by |dA| in two half-width partial products, then sums
// them and scales by the fraction bits.
// ============================================================================
`default_nettype none

module sip_scale #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SIDE_BITS  = 35
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [2*COORD_BITS:0]                 i_wa,
    input  logic [2*COORD_BITS+1:0]               i_sum,
    input  logic [COORD_BITS-1:0]                 i_mag_x,
    input  logic [COORD_BITS-1:0]                 i_mag_y,
    input  logic [SIDE_BITS-1:0]                  i_side,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [3*COORD_BITS+FRAC_BITS:0]       o_num_x,
    output logic [3*COORD_BITS+FRAC_BITS:0]       o_num_y,
    output logic [2*COORD_BITS+1:0]               o_den,
    output logic [SIDE_BITS-1:0]                  o_side
);

    localparam int C      = COORD_BITS;
    localparam int NW     = 3 * C + 1 + FRAC_BITS;
    localparam int STAGES = 2;

    logic [STAGES-1:0]   r_v;
    logic [STAGES:0]     w_adv;
    logic [2*C:0]        r_pl_x;
    logic [2*C:0]        r_pl_y;
    logic [2*C-1:0]      r_ph_x;
    logic [2*C-1:0]      r_ph_y;
    logic [3*C:0]        w_prod_x;
    logic [3*C:0]        w_prod_y;
    logic [NW-1:0]       r_num_x;
    logic [NW-1:0]       r_num_y;
    logic [2*C+1:0]      r_den  [STAGES];
    logic [SIDE_BITS-1:0] r_side [STAGES];

    // Bubble-collapsing stage control.
    assign w_adv[STAGES] = i_ready;
    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    endgenerate
    assign o_ready = w_adv[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < STAGES; s++) begin
                if (w_adv[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
                end
            end
        end
    end

    // Recombine the partial products of the upper and lower halves of |dA|.
    assign w_prod_x = {r_ph_x, {(C+1){1'b0}}} + (3*C+1)'(r_pl_x);
    assign w_prod_y = {r_ph_y, {(C+1){1'b0}}} + (3*C+1)'(r_pl_y);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_pl_x    <= (2*C+1)'(i_mag_x) * (2*C+1)'(i_wa[C:0]);
            r_ph_x    <= (2*C)'(i_mag_x) * (2*C)'(i_wa[2*C:C+1]);
            r_pl_y    <= (2*C+1)'(i_mag_y) * (2*C+1)'(i_wa[C:0]);
            r_ph_y    <= (2*C)'(i_mag_y) * (2*C)'(i_wa[2*C:C+1]);
            r_den[0]  <= i_sum;
            r_side[0] <= i_side;
        end
        if (w_adv[1]) begin
            r_num_x   <= NW'(w_prod_x) << FRAC_BITS;
            r_num_y   <= NW'(w_prod_y) << FRAC_BITS;
            r_den[1]  <= r_den[0];
            r_side[1] <= r_side[0];
        end
    end

    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_den   = r_den[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

`default_nettype wire

### rtl/core/sip_div.sv
// ============================================================================
// sip_div: pipelined restoring divider, two lanes, shared divisor
// Each stage resolves one quotient bit per lane with one compare-subtract;
// the final remainder leaves for rounding.
// ============================================================================
`default_nettype none

module sip_div #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SIDE_BITS  = 35
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [3*COORD_BITS+FRAC_BITS:0]   i_num_x,
    input  logic [3*COORD_BITS+FRAC_BITS:0]   i_num_y,
    input  logic [2*COORD_BITS+1:0]           i_den,
    input  logic [SIDE_BITS-1:0]              i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [COORD_BITS+FRAC_BITS-1:0]   o_quo_x,
    output logic [COORD_BITS+FRAC_BITS-1:0]   o_quo_y,
    output logic [2*COORD_BITS+1:0]           o_rem_x,
    output logic [2*COORD_BITS+1:0]           o_rem_y,
    output logic [2*COORD_BITS+1:0]           o_den,
    output logic [SIDE_BITS-1:0]              o_side
);

    localparam int QW = COORD_BITS + FRAC_BITS;
    localparam int DW = 2 * COORD_BITS + 2;
    localparam int NW = DW - 1 + QW;

    logic [QW-1:0]        r_v;
    logic [QW:0]          w_adv;
    logic [DW-1:0]        r_rem_x [QW];
    logic [DW-1:0]        r_rem_y [QW];
    logic [QW-1:0]        r_lo_x  [QW];
    logic [QW-1:0]        r_lo_y  [QW];
    logic [QW-1:0]        r_q_x   [QW];
    logic [QW-1:0]        r_q_y   [QW];
    logic [DW-1:0]        r_den   [QW];
    logic [SIDE_BITS-1:0] r_side  [QW];

    // Bubble-collapsing stage control.
    assign w_adv[QW] = i_ready;
    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    endgenerate
    assign o_ready = w_adv[0];
    assign o_valid = r_v[QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < QW; s++) begin
                if (w_adv[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
                end
            end
        end
    end

    // The quotient is below 2^QW, so the upper dividend bits start as a
    // partial remainder that is already smaller than the divisor.
    generate
        for (k = 0; k < QW; k++) begin : g_st
            logic [DW-1:0]  s_rem_x;
            logic [DW-1:0]  s_rem_y;
            logic [QW-1:0]  s_lo_x;
            logic [QW-1:0]  s_lo_y;
            logic [QW-1:0]  s_q_x;
            logic [QW-1:0]  s_q_y;
            logic [DW-1:0]  s_den;
            logic [SIDE_BITS-1:0] s_side;
            logic [DW:0]    t_x;
            logic [DW:0]    t_y;
            logic           ge_x;
            logic           ge_y;
            logic [DW:0]    d_x;
            logic [DW:0]    d_y;

            if (k == 0) begin : g_first
                assign s_rem_x = {1'b0, i_num_x[NW-1:QW]};
                assign s_rem_y = {1'b0, i_num_y[NW-1:QW]};
                assign s_lo_x  = i_num_x[QW-1:0];
                assign s_lo_y  = i_num_y[QW-1:0];
                assign s_q_x   = '0;
                assign s_q_y   = '0;
                assign s_den   = i_den;
                assign s_side  = i_side;
            end else begin : g_next
                assign s_rem_x = r_rem_x[k-1];
                assign s_rem_y = r_rem_y[k-1];
                assign s_lo_x  = r_lo_x[k-1];
                assign s_lo_y  = r_lo_y[k-1];
                assign s_q_x   = r_q_x[k-1];
                assign s_q_y   = r_q_y[k-1];
                assign s_den   = r_den[k-1];
                assign s_side  = r_side[k-1];
            end

            // Bring down the next dividend bit and try the subtraction.
            assign t_x  = {s_rem_x, s_lo_x[QW-1]};
            assign t_y  = {s_rem_y, s_lo_y[QW-1]};
            assign ge_x = t_x >= {1'b0, s_den};
            assign ge_y = t_y >= {1'b0, s_den};
            assign d_x  = t_x - {1'b0, s_den};
            assign d_y  = t_y - {1'b0, s_den};

            always_ff @(posedge i_clk) begin
                if (w_adv[k]) begin
                    r_rem_x[k] <= ge_x ? d_x[DW-1:0] : t_x[DW-1:0];
                    r_rem_y[k] <= ge_y ? d_y[DW-1:0] : t_y[DW-1:0];
                    r_lo_x[k]  <= {s_lo_x[QW-2:0], 1'b0};
                    r_lo_y[k]  <= {s_lo_y[QW-2:0], 1'b0};
                    r_q_x[k]   <= {s_q_x[QW-2:0], ge_x};
                    r_q_y[k]   <= {s_q_y[QW-2:0], ge_y};
                    r_den[k]   <= s_den;
                    r_side[k]  <= s_side;
                end
            end
        end
    endgenerate

    assign o_quo_x = r_q_x[QW-1];
    assign o_quo_y = r_q_y[QW-1];
    assign o_rem_x = r_rem_x[QW-1];
    assign o_rem_y = r_rem_y[QW-1];
    assign o_den   = r_den[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

### rtl/core/sip_place.sv
// ============================================================================
// sip_place: rounding and placement of the hit point
// Rounds the quotient to nearest, adds it with its sign to A, saturates to
// the 24-bit hit format and clears the result when there is no crossing.
// ============================================================================
`default_nettype none

module sip_place #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [COORD_BITS+FRAC_BITS-1:0]   i_quo_x,
    input  logic [COORD_BITS+FRAC_BITS-1:0]   i_quo_y,
    input  logic [2*COORD_BITS+1:0]           i_rem_x,
    input  logic [2*COORD_BITS+1:0]           i_rem_y,
    input  logic [2*COORD_BITS+1:0]           i_den,
    input  logic [2*COORD_BITS+2:0]           i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_crossed,
    output logic [sip_pkg::HIT_BITS-1:0]      o_hit_x,
    output logic [sip_pkg::HIT_BITS-1:0]      o_hit_y
);

    import sip_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int QW     = COORD_BITS + FRAC_BITS;
    localparam int SW     = 2 * COORD_BITS + 3;
    localparam int VW     = COORD_BITS + FRAC_BITS + 2;
    localparam int EW     = (VW > HIT_BITS) ? VW : HIT_BITS + 1;
    localparam int STAGES = 2;
    localparam logic signed [EW-1:0] MAX_E = EW'(HIT_MAX);
    localparam logic signed [EW-1:0] MIN_E = EW'(HIT_MIN);

    logic [STAGES-1:0]      r_v;
    logic [STAGES:0]        w_adv;
    logic [QW:0]            r_off_x;
    logic [QW:0]            r_off_y;
    logic [SW-1:0]          r_side;
    logic signed [C-1:0]    w_base_x;
    logic signed [C-1:0]    w_base_y;
    logic signed [VW-1:0]   w_vb_x;
    logic signed [VW-1:0]   w_vb_y;
    logic signed [VW-1:0]   w_v_x;
    logic signed [VW-1:0]   w_v_y;
    logic signed [EW-1:0]   w_e_x;
    logic signed [EW-1:0]   w_e_y;
    logic [HIT_BITS-1:0]    w_sat_x;
    logic [HIT_BITS-1:0]    w_sat_y;
    logic                   r_crossed;
    logic [HIT_BITS-1:0]    r_hit_x;
    logic [HIT_BITS-1:0]    r_hit_y;

    // Bubble-collapsing stage control; the last stage is the output register.
    assign w_adv[STAGES] = i_ready;
    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    endgenerate
    assign o_ready = w_adv[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < STAGES; s++) begin
                if (w_adv[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
                end
            end
        end
    end

    // Side fields: base_x, base_y, neg_x, neg_y, crossed from the lowest bit.
    assign w_base_x = r_side[C-1:0];
    assign w_base_y = r_side[2*C-1:C];

    // Base point in fixed point, then the signed offset.
    assign w_vb_x = VW'(w_base_x) <<< FRAC_BITS;
    assign w_vb_y = VW'(w_base_y) <<< FRAC_BITS;
    assign w_v_x  = r_side[2*C]   ? w_vb_x - $signed({1'b0, r_off_x})
                                  : w_vb_x + $signed({1'b0, r_off_x});
    assign w_v_y  = r_side[2*C+1] ? w_vb_y - $signed({1'b0, r_off_y})
                                  : w_vb_y + $signed({1'b0, r_off_y});
    assign w_e_x  = EW'(w_v_x);
    assign w_e_y  = EW'(w_v_y);

    // Clamp to the 24-bit hit range.
    assign w_sat_x = (w_e_x > MAX_E) ? MAX_E[HIT_BITS-1:0]
                   : (w_e_x < MIN_E) ? MIN_E[HIT_BITS-1:0] : w_e_x[HIT_BITS-1:0];
    assign w_sat_y = (w_e_y > MAX_E) ? MAX_E[HIT_BITS-1:0]
                   : (w_e_y < MIN_E) ? MIN_E[HIT_BITS-1:0] : w_e_y[HIT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        // Round to nearest, ties away from zero on the magnitude.
        if (w_adv[0]) begin
            r_off_x <= {1'b0, i_quo_x} + (QW+1)'({i_rem_x, 1'b0} >= {1'b0, i_den});
            r_off_y <= {1'b0, i_quo_y} + (QW+1)'({i_rem_y, 1'b0} >= {1'b0, i_den});
            r_side  <= i_side;
        end
        if (w_adv[1]) begin
            r_crossed <= r_side[SW-1];
            r_hit_x   <= r_side[SW-1] ? w_sat_x : '0;
            r_hit_y   <= r_side[SW-1] ? w_sat_y : '0;
        end
    end

    assign o_crossed = r_crossed;
    assign o_hit_x   = r_hit_x;
    assign o_hit_y   = r_hit_y;

endmodule

`default_nettype wire

### rtl/core/sip_check.sv
// ============================================================================
// sip_check: port-level checks for segment_intersection_point
// Watches the stream ports over time and is bound to the top level.
// ============================================================================
`default_nettype none

module sip_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sip_pkg::M_DATA_BITS-1:0]  m_tdata,
    input logic [0:0]                       m_tuser
);

    import sip_pkg::*;

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // A beat without a crossing carries the origin.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("non-crossing beat carries a nonzero point");

    // Reset empties the pipeline, so it is ready and shows nothing.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // A drained output lets the whole pipeline advance.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is being drained");

endmodule

bind segment_intersection_point sip_check u_sip_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/segment_intersection_point_tb.sv
// ============================================================================
// segment_intersection_point_tb: self-checking bench for the crossing block
// Streams segment pairs into the block, predicts each crossing flag and hit
// point in the bench, and checks every output beat in order. Random idle
// bursts fall on both sides, and one long receiver hold-off backs the
// pipeline up into the input.
// ============================================================================
module segment_intersection_point_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = sip_pkg::COORD_BITS_DEF;
    localparam int FW           = sip_pkg::FRAC_BITS_DEF;
    localparam int HW           = sip_pkg::HIT_BITS;
    localparam int RANDOM_PAIRS = 600;
    localparam int QUIET_TAIL   = 100;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // Segment pair in beat order: a_x sits in the lowest bits.
    typedef struct packed {
        logic signed [CW-1:0] d_y;
        logic signed [CW-1:0] d_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_x;
    } seg_pair_t;

    typedef struct packed {
        logic                 crossed;
        logic signed [HW-1:0] hit_y;
        logic signed [HW-1:0] hit_x;
    } hit_t;

    logic                          i_clk    = 1'b0;
    logic                          i_rst_n  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up
    logic [8*CW-1:0]               s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // hit_x, hit_y from the lowest bit up
    logic [sip_pkg::M_DATA_BITS-1:0] m_tdata;
    // crossed
    logic [0:0]                    m_tuser;

    seg_pair_t pending_pairs[$];
    hit_t      expected_hits[$];
    int        total_pairs  = 0;
    int        results_seen = 0;
    int        mismatches   = 0;
    int        cycle_count  = 0;
    int        send_gap     = 0;
    int        recv_gap     = 0;
    int        hold_cnt     = 0;
    logic      hold_busy    = 1'b0;
    logic      hold_done    = 1'b0;
    hit_t      dut_hit;
    hit_t      want_hit;

    segment_intersection_point i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign dut_hit = {m_tuser[0], m_tdata[2*HW-1:HW], m_tdata[HW-1:0]};

    // One hit coordinate: base plus the rounded weighted offset, saturated.
    function automatic logic signed [HW-1:0] hit_coord(longint base, longint delta,
                                                        longint unsigned wa,
                                                        longint unsigned sum);
        longint unsigned mag;
        longint unsigned num;
        longint unsigned q;
        longint unsigned r;
        longint          v;
        mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        num = (mag << FW) * wa;
        q   = num / sum;
        r   = num % sum;
        // Round to nearest on the magnitude, ties away from zero.
        if (2 * r >= sum) q = q + 1;
        v = base * (longint'(1) << FW);
        v = (delta < 0) ? v - longint'(q) : v + longint'(q);
        if (v > sip_pkg::HIT_MAX) v = longint'(sip_pkg::HIT_MAX);
        if (v < sip_pkg::HIT_MIN) v = longint'(sip_pkg::HIT_MIN);
        return v[HW-1:0];
    endfunction

    // Crossing flag and point of one segment pair.
    function automatic hit_t predict_crossing(seg_pair_t p);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint side_a, side_b, side_c, side_d;
        longint unsigned wa, wb;
        hit_t h;
        ax = longint'(p.a_x); ay = longint'(p.a_y);
        bx = longint'(p.b_x); by = longint'(p.b_y);
        cx = longint'(p.c_x); cy = longint'(p.c_y);
        dx = longint'(p.d_x); dy = longint'(p.d_y);
        side_a = (cx - dx) * (ay - cy) + (cy - dy) * (cx - ax);
        side_b = (cx - dx) * (by - cy) + (cy - dy) * (cx - bx);
        side_c = (ax - bx) * (cy - ay) + (ay - by) * (ax - cx);
        side_d = (ax - bx) * (dy - ay) + (ay - by) * (ax - dx);
        h = '0;
        // Only strict sign changes on both lines count as a crossing.
        if (((side_a > 0 && side_b < 0) || (side_a < 0 && side_b > 0)) &&
            ((side_c > 0 && side_d < 0) || (side_c < 0 && side_d > 0))) begin
            wa = (side_a < 0) ? longint'(-side_a) : longint'(side_a);
            wb = (side_b < 0) ? longint'(-side_b) : longint'(side_b);
            h.crossed = 1'b1;
            h.hit_x   = hit_coord(ax, bx - ax, wa, wa + wb);
            h.hit_y   = hit_coord(ay, by - ay, wa, wa + wb);
        end
        return h;
    endfunction

    function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                            int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.a_x = CW'(ax); p.a_y = CW'(ay); p.b_x = CW'(bx); p.b_y = CW'(by);
        p.c_x = CW'(cx); p.c_y = CW'(cy); p.d_x = CW'(dx); p.d_y = CW'(dy);
        return p;
    endfunction

    function automatic int signed_rand(int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // Random pair: mostly built crossings, some full-range noise, some tiny grids.
    function automatic seg_pair_t random_pair();
        int amp, ax, ay, wx, wy, px, py, vx, vy;
        int mode;
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 2))
            0: amp = 7;
            1: amp = 255;
            default: amp = 8191;
        endcase
        if (mode <= 5) begin
            // Line CD runs close to the midpoint of AB, nudged off the lattice.
            ax = signed_rand(amp); ay = signed_rand(amp);
            wx = signed_rand(amp); wy = signed_rand(amp);
            vx = signed_rand(amp); vy = signed_rand(amp);
            px = ax + wx;          py = ay + wy;
            return make_pair(ax, ay, ax + 2 * wx, ay + 2 * wy,
                             px + vx, py + vy,
                             px - vx + signed_rand(3), py - vy + signed_rand(3));
        end else if (mode <= 7) begin
            return seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
        end
        // Tiny grid: touching, collinear and degenerate pairs are common here.
        return make_pair(signed_rand(2), signed_rand(2), signed_rand(2), signed_rand(2),
                         signed_rand(2), signed_rand(2), signed_rand(2), signed_rand(2));
    endfunction

    // Clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Stimulus, reset and end of run.
    initial begin
        // Plain crossings, including an off-center one.
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        pending_pairs.push_back(make_pair(0, 0, 3, 0, 1, -1, 2, 2));
        // Half-step offsets that round away from zero in both directions.
        pending_pairs.push_back(make_pair(0, 0, 1, 0, 0, -1, 1, 511));
        pending_pairs.push_back(make_pair(0, 0, -1, 0, 0, -1, -1, 511));
        // Shared endpoint, endpoint on the other segment, collinear, parallel.
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
        // Point segment, identical segments, lines crossing outside a segment.
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
        pending_pairs.push_back(make_pair(1, 2, 7, 9, 1, 2, 7, 9));
        pending_pairs.push_back(make_pair(0, 0, 1, 1, 10, 0, 0, 10));
        // Full-scale diagonals in both directions, then the two full-scale axes.
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
                                          32767, -32768, -32768, 32767));
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          -32768, -32768, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        // Nearly parallel full-length segments.
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, -32767, 32767, 32766));
        // Endpoint on a full-scale line, all fields at one extreme, minus one.
        pending_pairs.push_back(make_pair(-32768, 32767, 32767, 32767,
                                          0, -32768, 1, 32767));
        pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_pairs.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            pending_pairs.push_back(random_pair());
        end
        total_pairs = pending_pairs.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || s_tvalid || expected_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("segment_intersection_point test passed");
        end else begin
            $display("segment_intersection_point test failed");
        end
        $finish;
    end

    // Input driver: offers pending pairs with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_hits.push_back(predict_crossing(seg_pair_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    s_tdata  <= pending_pairs.pop_front();
                    s_tvalid <= 1'b1;
                    if (pending_pairs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                        send_gap <= $urandom_range(1, 11);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once the run is under way.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_busy <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_cnt  <= hold_cnt + 1;
            hold_busy <= (hold_cnt != HOLD_CYCLES - 1);
            hold_done <= (hold_cnt == HOLD_CYCLES - 1);
        end
    end

    // Output ready with random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else if (hold_busy) begin
            m_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (results_seen < total_pairs - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(1, 11);
            end
        end
    end

    // Output monitor: each beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected output beat, actual crossed %0d x %0d y %0d",
                         $time, dut_hit.crossed, dut_hit.hit_x, dut_hit.hit_y);
                mismatches++;
            end else begin
                want_hit = expected_hits.pop_front();
                if (dut_hit.crossed !== want_hit.crossed) begin
                    $display("%0t: crossed mismatch, expected %0d, actual %0d",
                             $time, want_hit.crossed, dut_hit.crossed);
                    mismatches++;
                end
                if (dut_hit.hit_x !== want_hit.hit_x) begin
                    $display("%0t: hit_x mismatch, expected %0d, actual %0d",
                             $time, want_hit.hit_x, dut_hit.hit_x);
                    mismatches++;
                end
                if (dut_hit.hit_y !== want_hit.hit_y) begin
                    $display("%0t: hit_y mismatch, expected %0d, actual %0d",
                             $time, want_hit.hit_y, dut_hit.hit_y);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("segment_intersection_point test failed");
            $finish;
        end
    end

endmodule
